// File: sv/gbktl_pkg.sv
// shared types, constants and helpers of the gbk text layout glyph addresser
package gbktl_pkg;

   // result command codes, carried on rsp_tuser
   localparam logic [1:0] CMD_NARROW = 2'd0;
   localparam logic [1:0] CMD_GLYPH  = 2'd1;
   localparam logic [1:0] CMD_BLANK  = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_BOX_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_BOX_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FONT_BASE  = 2'd2;

   localparam logic [11:0] BOX_WIDTH_RESET  = 12'd200;
   localparam logic [11:0] BOX_HEIGHT_RESET = 12'd16;
   localparam logic [23:0] FONT_BASE_RESET  = 24'd0;

   // character sizes and line pitch in pixels
   localparam logic [4:0] NARROW_W   = 5'd8;
   localparam logic [4:0] WIDE_W     = 5'd16;
   localparam logic [4:0] LINE_PITCH = 5'd16;

   // glyph table geometry
   localparam int GLYPH_BYTES   = 32;
   localparam int GLYPH_SHIFT   = $clog2(GLYPH_BYTES);
   localparam int CODES_PER_ROW = 190;

   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] LEAD_LIMIT = 8'h80;
   localparam logic [7:0] LEAD_FIRST = 8'h81;
   localparam logic [7:0] LEAD_BAD   = 8'hff;
   localparam logic [7:0] TRAIL_LOW  = 8'h40;
   localparam logic [7:0] TRAIL_GAP  = 8'h7f;
   localparam logic [7:0] TRAIL_HIGH = 8'h41;
   localparam logic [7:0] TRAIL_BAD  = 8'hff;

   // cursor after the wrap check, and whether the character still fits
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        fit;
   } place_type;

   function automatic logic [15:0] sat16(input logic [16:0] v);
      return v[16] ? 16'hffff : v[15:0];
   endfunction

endpackage

// File: sv/gbk_text_layout_glyph_addresser.sv
// top level: byte stream text layout with gbk glyph flash addressing
//
// Takes one string byte per beat on req_ and gives at most one draw command
// per beat on rsp_. A new string starts with req_tuser high, which loads the
// origin from req_tdata. Narrow characters (bytes up to 0x80) advance 8
// pixels, two-byte gbk characters 16 pixels; the lead byte gives no beat and
// the command comes with the trail byte. The cursor wraps to the next line
// (16 pixels down) before a character that would pass the box width, and the
// string ends with a finish command before a character that would pass the
// box height. A CR starts a new line and drops the byte after it. A zero byte
// ends the string. Between strings the block ignores bytes that do not start
// a new string. Rate: one byte per clock, every clock, while rsp_tready is
// high; the whole layout step (wrap add and compare, height compare, glyph
// index multiply by a constant and base add) is one pass of logic from the
// cursor registers into the result register, so a command is valid on rsp_
// in the cycle after its byte is taken. A new byte is taken at the same edge
// where the waiting beat leaves, so req_tready only drops when rsp_ is
// stalled with a beat held. No flash reads are issued here: the command
// carries the address.
module gbk_text_layout_glyph_addresser (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // text_byte[7:0], origin_x[23:8], origin_y[39:24]
   input  logic        req_tuser,   // first_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pos_x[15:0], pos_y[31:16], char_code[39:32],
                                    // flash_address[63:40]
   output logic [1:0]  rsp_tuser,   // command
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   // config registers
   logic [11:0] box_width_ff;
   logic [11:0] box_height_ff;
   logic [23:0] font_base_ff;

   // layout state
   logic [15:0] cursor_x_ff,  cursor_x_in;
   logic [15:0] cursor_y_ff,  cursor_y_in;
   logic [15:0] line_x_ff,    line_x_in;
   logic [15:0] top_y_ff,     top_y_in;
   logic [7:0]  lead_ff,      lead_in;
   logic        lead_pend_ff, lead_pend_in;
   logic        skip_ff,      skip_in;
   logic        done_ff,      done_in;

   // result register
   logic        rsp_valid_ff;
   logic [1:0]  rsp_cmd_ff,   rsp_cmd_in;
   logic [63:0] rsp_data_ff,  rsp_data_in;
   logic        emit_in;

   logic        accept;
   logic [7:0]  text_byte;

   assign text_byte  = req_tdata[7:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_cmd_ff;

   // wrap to the next line if the character passes the box width, then
   // check the box height; sums are 17 bits wide so they never wrap
   function automatic gbktl_pkg::place_type place_char(
      input logic [15:0] x, input logic [15:0] y,
      input logic [15:0] lx, input logic [15:0] ty,
      input logic [4:0]  w,
      input logic [11:0] bw, input logic [11:0] bh);
      gbktl_pkg::place_type p;
      p.x = x;
      p.y = y;
      if ({1'b0, x} + {12'd0, w} > {1'b0, lx} + {5'd0, bw}) begin
         p.y = gbktl_pkg::sat16({1'b0, y} + {12'd0, gbktl_pkg::LINE_PITCH});
         p.x = lx;
      end
      p.fit = !({1'b0, p.y} + {12'd0, w} > {1'b0, ty} + {5'd0, bh});
      return p;
   endfunction

   // layout step for one byte
   always_comb begin
      gbktl_pkg::place_type pl;
      logic [6:0]  row;
      logic [7:0]  col;
      logic [14:0] idx;
      logic [23:0] offset;
      logic [7:0]  code;
      logic [23:0] addr;
      logic [15:0] px;
      logic [15:0] py;

      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      line_x_in    = line_x_ff;
      top_y_in     = top_y_ff;
      lead_in      = lead_ff;
      lead_pend_in = lead_pend_ff;
      skip_in      = skip_ff;
      done_in      = done_ff;
      emit_in      = 1'b0;
      rsp_cmd_in   = gbktl_pkg::CMD_FINISH;
      code         = 8'd0;
      addr         = 24'd0;
      px           = cursor_x_ff;
      py           = cursor_y_ff;
      pl           = '0;

      // glyph index: row * 190 + col, times the glyph size
      row    = lead_ff[6:0] - gbktl_pkg::LEAD_FIRST[6:0];
      col    = (text_byte < gbktl_pkg::TRAIL_GAP) ? text_byte - gbktl_pkg::TRAIL_LOW
                                                  : text_byte - gbktl_pkg::TRAIL_HIGH;
      idx    = 15'(row * 15'(gbktl_pkg::CODES_PER_ROW)) + {7'd0, col};
      offset = {4'd0, idx, {gbktl_pkg::GLYPH_SHIFT{1'b0}}};

      // start of a new string
      if (req_tuser) begin
         line_x_in    = req_tdata[23:8];
         top_y_in     = req_tdata[39:24];
         cursor_x_in  = req_tdata[23:8];
         cursor_y_in  = req_tdata[39:24];
         lead_in      = 8'd0;
         lead_pend_in = 1'b0;
         skip_in      = 1'b0;
         done_in      = 1'b0;
      end

      if (!done_in) begin
         if (skip_in) begin
            // byte swallowed after a cr, but a zero still ends the string
            skip_in = 1'b0;
            if (text_byte == gbktl_pkg::CHAR_END) begin
               emit_in = 1'b1;
            end
         end else if (lead_pend_in) begin
            lead_pend_in = 1'b0;
            if (text_byte == gbktl_pkg::CHAR_END) begin
               emit_in = 1'b1;
            end else begin
               pl = place_char(cursor_x_in, cursor_y_in, line_x_in, top_y_in,
                               gbktl_pkg::WIDE_W, box_width_ff, box_height_ff);
               cursor_x_in = pl.x;
               cursor_y_in = pl.y;
               emit_in     = 1'b1;
               if (pl.fit) begin
                  px = pl.x;
                  py = pl.y;
                  if (lead_ff < gbktl_pkg::LEAD_FIRST || lead_ff == gbktl_pkg::LEAD_BAD ||
                      text_byte < gbktl_pkg::TRAIL_LOW ||
                      text_byte == gbktl_pkg::TRAIL_BAD) begin
                     rsp_cmd_in = gbktl_pkg::CMD_BLANK;
                  end else begin
                     rsp_cmd_in = gbktl_pkg::CMD_GLYPH;
                     addr       = font_base_ff + offset;
                  end
                  cursor_x_in = gbktl_pkg::sat16({1'b0, pl.x} + {12'd0, gbktl_pkg::WIDE_W});
               end
            end
         end else if (text_byte == gbktl_pkg::CHAR_END) begin
            emit_in = 1'b1;
         end else if (text_byte > gbktl_pkg::LEAD_LIMIT) begin
            // lead byte of a wide character: held for the trail byte
            lead_in      = text_byte;
            lead_pend_in = 1'b1;
         end else begin
            pl = place_char(cursor_x_in, cursor_y_in, line_x_in, top_y_in,
                            gbktl_pkg::NARROW_W, box_width_ff, box_height_ff);
            cursor_x_in = pl.x;
            cursor_y_in = pl.y;
            if (!pl.fit) begin
               emit_in = 1'b1;
            end else if (text_byte == gbktl_pkg::CHAR_CR) begin
               cursor_y_in = gbktl_pkg::sat16({1'b0, pl.y} + {12'd0, gbktl_pkg::LINE_PITCH});
               cursor_x_in = line_x_in;
               skip_in     = 1'b1;
            end else begin
               emit_in     = 1'b1;
               rsp_cmd_in  = gbktl_pkg::CMD_NARROW;
               code        = text_byte;
               px          = pl.x;
               py          = pl.y;
               cursor_x_in = gbktl_pkg::sat16({1'b0, pl.x} + {12'd0, gbktl_pkg::NARROW_W});
            end
         end

         // a finish beat reports the cursor and parks the block
         if (emit_in && rsp_cmd_in == gbktl_pkg::CMD_FINISH) begin
            px           = cursor_x_in;
            py           = cursor_y_in;
            done_in      = 1'b1;
            lead_pend_in = 1'b0;
            skip_in      = 1'b0;
         end
      end

      rsp_data_in = {addr, code, py, px};
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         box_width_ff  <= gbktl_pkg::BOX_WIDTH_RESET;
         box_height_ff <= gbktl_pkg::BOX_HEIGHT_RESET;
         font_base_ff  <= gbktl_pkg::FONT_BASE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            gbktl_pkg::CSR_BOX_WIDTH: begin
               box_width_ff <= csr_wdata[11:0];
            end
            gbktl_pkg::CSR_BOX_HEIGHT: begin
               box_height_ff <= csr_wdata[11:0];
            end
            gbktl_pkg::CSR_FONT_BASE: begin
               font_base_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // layout state, moves on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= 16'd0;
         cursor_y_ff  <= 16'd0;
         line_x_ff    <= 16'd0;
         top_y_ff     <= 16'd0;
         lead_ff      <= 8'd0;
         lead_pend_ff <= 1'b0;
         skip_ff      <= 1'b0;
         done_ff      <= 1'b1;
      end else if (accept) begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         line_x_ff    <= line_x_in;
         top_y_ff     <= top_y_in;
         lead_ff      <= lead_in;
         lead_pend_ff <= lead_pend_in;
         skip_ff      <= skip_in;
         done_ff      <= done_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit_in) begin
         rsp_cmd_ff  <= rsp_cmd_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: sv/gbktl_checker.sv
// port level checks of the gbk text layout glyph addresser, bound to the top level
module gbktl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // a stalled, full result register blocks new bytes
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("byte taken while result register full and stalled");

   // a result beat only shows up after an accepted byte
   a_beat_after_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result beat without an accepted byte");

   // only a real glyph carries a flash address
   a_addr_only_glyph: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != gbktl_pkg::CMD_GLYPH |-> rsp_tdata[63:40] == 24'd0)
      else $error("flash address on a non glyph command");

   // only a narrow character carries a char code
   a_code_only_narrow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != gbktl_pkg::CMD_NARROW |-> rsp_tdata[39:32] == 8'd0)
      else $error("char code on a non narrow command");

endmodule

bind gbk_text_layout_glyph_addresser gbktl_checker u_gbktl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: sim/gbk_layout_checker.sv
// checker: predicts the draw commands of the gbk text layout block and compares the result stream
`timescale 1ns / 1ps
module gbk_layout_checker
   import gbktl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [23:0] csr_wdata,
   output int          mismatches,
   output int          pending_draws
);

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  char_code;
      logic [23:0] flash_address;
   } draw_beat_type;

   logic [11:0] box_w;
   logic [11:0] box_h;
   logic [23:0] glyph_base;

   logic [15:0] cur_x;
   logic [15:0] cur_y;
   logic [15:0] line_x;
   logic [15:0] top_y;
   logic [7:0]  lead_byte;
   logic        lead_held;
   logic        drop_next;
   logic        idle;

   draw_beat_type expected_draws[$];

   function automatic logic [15:0] clamp16(input int v);
      return (v > 65535) ? 16'hffff : v[15:0];
   endfunction

   task automatic close_string(output draw_beat_type beat);
      idle = 1'b1;
      lead_held = 1'b0;
      drop_next = 1'b0;
      beat = '0;
      beat.command = CMD_FINISH;
      beat.pos_x = cur_x;
      beat.pos_y = cur_y;
   endtask

   // wrap to the next line if needed, then check the box height
   task automatic wrap_and_fit(input int w, output logic fits);
      if (int'(cur_x) + w > int'(line_x) + int'(box_w)) begin
         cur_y = clamp16(int'(cur_y) + int'(LINE_PITCH));
         cur_x = line_x;
      end
      fits = !(int'(cur_y) + w > int'(top_y) + int'(box_h));
   endtask

   task automatic layout_byte(input logic [7:0] b, input logic first,
                              input logic [15:0] ox, input logic [15:0] oy,
                              output logic made, output draw_beat_type beat);
      logic fits;
      int   row;
      int   col;
      made = 1'b0;
      beat = '0;
      if (first) begin
         line_x = ox;
         top_y = oy;
         cur_x = ox;
         cur_y = oy;
         lead_byte = 8'h00;
         lead_held = 1'b0;
         drop_next = 1'b0;
         idle = 1'b0;
      end
      if (idle) return;
      if (drop_next) begin
         drop_next = 1'b0;
         if (b == CHAR_END) begin
            close_string(beat);
            made = 1'b1;
         end
         return;
      end
      made = 1'b1;
      if (lead_held) begin
         lead_held = 1'b0;
         if (b == CHAR_END) begin
            close_string(beat);
            return;
         end
         wrap_and_fit(int'(WIDE_W), fits);
         if (!fits) begin
            close_string(beat);
            return;
         end
         beat.pos_x = cur_x;
         beat.pos_y = cur_y;
         if (lead_byte < LEAD_FIRST || b < TRAIL_LOW || b == TRAIL_BAD || lead_byte == LEAD_BAD)
            beat.command = CMD_BLANK;
         else begin
            col = (b < TRAIL_GAP) ? int'(b) - int'(TRAIL_LOW) : int'(b) - int'(TRAIL_HIGH);
            row = int'(lead_byte) - int'(LEAD_FIRST);
            beat.command = CMD_GLYPH;
            beat.flash_address = glyph_base + 24'((CODES_PER_ROW * row + col) * GLYPH_BYTES);
         end
         cur_x = clamp16(int'(cur_x) + int'(WIDE_W));
         return;
      end
      if (b == CHAR_END) begin
         close_string(beat);
         return;
      end
      if (b > LEAD_LIMIT) begin
         lead_byte = b;
         lead_held = 1'b1;
         made = 1'b0;
         return;
      end
      wrap_and_fit(int'(NARROW_W), fits);
      if (!fits) begin
         close_string(beat);
         return;
      end
      if (b == CHAR_CR) begin
         cur_y = clamp16(int'(cur_y) + int'(LINE_PITCH));
         cur_x = line_x;
         drop_next = 1'b1;
         made = 1'b0;
         return;
      end
      beat.command = CMD_NARROW;
      beat.pos_x = cur_x;
      beat.pos_y = cur_y;
      beat.char_code = b;
      cur_x = clamp16(int'(cur_x) + int'(NARROW_W));
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_draw(input draw_beat_type got);
      draw_beat_type want;
      if (expected_draws.size() == 0) begin
         report_mismatch($sformatf("unexpected beat cmd %0d at (%0d,%0d)",
                                   got.command, got.pos_x, got.pos_y));
         return;
      end
      want = expected_draws.pop_front();
      if (got.command != want.command)
         report_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
      if (got.pos_x != want.pos_x)
         report_mismatch($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
      if (got.pos_y != want.pos_y)
         report_mismatch($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
      if (got.char_code != want.char_code)
         report_mismatch($sformatf("char_code %h, want %h", got.char_code, want.char_code));
      if (got.flash_address != want.flash_address)
         report_mismatch($sformatf("flash_address %h, want %h",
                                   got.flash_address, want.flash_address));
   endtask

   always @(posedge clock) begin : watch
      draw_beat_type got;
      draw_beat_type want;
      logic          made;
      if (reset) begin
         box_w = BOX_WIDTH_RESET;
         box_h = BOX_HEIGHT_RESET;
         glyph_base = FONT_BASE_RESET;
         cur_x = '0;
         cur_y = '0;
         line_x = '0;
         top_y = '0;
         lead_byte = '0;
         lead_held = 1'b0;
         drop_next = 1'b0;
         idle = 1'b1;
         expected_draws.delete();
      end else begin
         // a result at this edge always belongs to an earlier byte
         if (rsp_tvalid && rsp_tready) begin
            got.command = rsp_tuser;
            got.pos_x = rsp_tdata[15:0];
            got.pos_y = rsp_tdata[31:16];
            got.char_code = rsp_tdata[39:32];
            got.flash_address = rsp_tdata[63:40];
            check_draw(got);
         end
         if (req_tvalid && req_tready) begin
            layout_byte(req_tdata[7:0], req_tuser, req_tdata[23:8], req_tdata[39:24],
                        made, want);
            if (made) expected_draws.push_back(want);
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_BOX_WIDTH:  box_w = csr_wdata[11:0];
               CSR_BOX_HEIGHT: box_h = csr_wdata[11:0];
               CSR_FONT_BASE:  glyph_base = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_draws = expected_draws.size();
   end

endmodule

// File: sim/tb_top.sv
// testbench top: feeds text strings and box setups to the gbk layout block and gives the verdict
`timescale 1ns / 1ps
module tb_top;
   import gbktl_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
   localparam int SETTLE_CYCLES = 8;       // a lead byte may still sit in the block
   localparam int HOLD_CYCLES   = 300;     // long receiver stall to back up the input
   localparam int PHASE_ITEMS   = 145;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // text_byte[7:0], origin_x[23:8], origin_y[39:24]
   logic        req_tuser = 1'b0; // first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // pos_x[15:0], pos_y[31:16], char_code[39:32],
                                  // flash_address[63:40]
   logic [1:0]  rsp_tuser;        // command
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = CSR_BOX_WIDTH;
   logic [23:0] csr_wdata = '0;

   int mismatches;
   int pending_draws;
   int send_idle = 0;      // percent of cycles the sender holds back
   int recv_idle = 0;      // percent of cycles the receiver holds back
   int items_sent = 0;
   int cycles = 0;
   int hold_requests = 0;  // bumped by the stimulus to ask for a long stall
   int hold_seen = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   gbk_text_layout_glyph_addresser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   gbk_layout_checker layout_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_draws (pending_draws)
   );

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random backpressure, or a long stall when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // one request beat; called and returns at a falling edge
   task automatic send_beat(input logic first, input logic [7:0] ch,
                            input logic [15:0] ox, input logic [15:0] oy);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= {oy, ox, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // continuation byte; origin bits are don't-care, so they get noise
   task automatic send_char(input logic [7:0] ch);
      send_beat(1'b0, ch, 16'($urandom), 16'($urandom));
   endtask

   // mostly small origins, some near the top of the range to reach saturation
   function automatic logic [15:0] pick_origin();
      case ($urandom_range(7))
         0:       return 16'($urandom);
         1:       return 16'hffff - 16'($urandom_range(64));
         default: return 16'($urandom_range(300));
      endcase
   endfunction

   function automatic logic [7:0] pick_narrow();
      logic [7:0] c = 8'($urandom_range(1, 128));
      return (c == CHAR_CR) ? 8'h41 : c;
   endfunction

   function automatic logic [7:0] pick_lead();
      return 8'($urandom_range(8'h81, 8'hfe));
   endfunction

   // one character of a string: narrow, gbk pair, bad pair, cr, cut pair, restart or noise
   task automatic send_token();
      int roll = $urandom_range(99);
      if (roll < 45)
         send_char(pick_narrow());
      else if (roll < 75) begin
         send_char(pick_lead());
         send_char(8'($urandom_range(8'h40, 8'hfe)));
      end else if (roll < 83) begin
         case ($urandom_range(2))
            0: begin
               send_char(LEAD_BAD);
               send_char(8'($urandom_range(1, 255)));
            end
            1: begin
               send_char(pick_lead());
               send_char(8'($urandom_range(1, 8'h3f)));
            end
            default: begin
               send_char(pick_lead());
               send_char(TRAIL_BAD);
            end
         endcase
      end else if (roll < 92) begin
         // cr swallows the next byte, sometimes the terminator itself
         send_char(CHAR_CR);
         send_char(($urandom_range(7) == 0) ? CHAR_END : 8'($urandom_range(1, 255)));
      end else if (roll < 96) begin
         send_char(pick_lead());
         send_char(CHAR_END);
      end else if ($urandom_range(15) == 0)
         send_beat(1'b1, 8'($urandom), pick_origin(), pick_origin());
      else
         send_char(8'($urandom));
   endtask

   task automatic send_string();
      int len = $urandom_range(1, 40);
      send_beat(1'b1, pick_narrow(), pick_origin(), pick_origin());
      repeat (len) send_token();
      send_char(CHAR_END);
      // stray byte between strings, to be ignored
      if ($urandom_range(9) == 0) send_char(8'($urandom));
   endtask

   // drop valid, drain all expected beats, then let a held lead byte settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_draws != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all three registers back to back; upper bits of the narrow ones are noise
   task automatic write_box_setup(input logic [11:0] w, input logic [11:0] h,
                                  input logic [23:0] base);
      csr_we <= 1'b1;
      csr_addr <= CSR_BOX_WIDTH;
      csr_wdata <= {12'($urandom), w};
      @(negedge clock);
      csr_addr <= CSR_BOX_HEIGHT;
      csr_wdata <= {12'($urandom), h};
      @(negedge clock);
      csr_addr <= CSR_FONT_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [11:0] w, input logic [11:0] h, input logic [23:0] base,
                            input int s_idle, input int r_idle, input logic long_stall);
      int target;
      drain();
      write_box_setup(w, h, base);
      send_idle = s_idle;
      recv_idle = r_idle;
      if (long_stall) hold_requests++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_string();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings at the reset setup: 200 wide, one line high, base 0
      send_idle = 34;
      recv_idle = 83;
      send_char(8'h41);                           // idle, ignored
      send_beat(1'b1, 8'h41, 16'h0000, 16'h0000);
      send_char(LEAD_LIMIT);                      // highest narrow byte
      send_char(LEAD_FIRST);                      // first valid gbk code
      send_char(TRAIL_LOW);
      send_char(8'hfe);                           // last valid gbk code
      send_char(8'hfe);
      send_char(LEAD_FIRST);                      // trail right at the gap
      send_char(TRAIL_GAP);
      send_char(LEAD_BAD);                        // bad lead, blank glyph
      send_char(TRAIL_LOW);
      send_char(LEAD_FIRST);                      // trail too low
      send_char(8'h3f);
      send_char(LEAD_FIRST);                      // bad trail
      send_char(TRAIL_BAD);
      send_char(CHAR_CR);                         // new line, swallows the next byte
      send_char(8'h78);
      send_char(8'h79);                           // past the box height, ends the string
      send_beat(1'b1, LEAD_BAD, 16'hffff, 16'hffff);
      send_char(CHAR_END);                        // zero trail drops the lone lead
      send_beat(1'b1, CHAR_CR, 16'h0005, 16'h0007);
      send_char(CHAR_END);                        // swallowed zero still ends
      send_beat(1'b1, CHAR_END, 16'h1234, 16'h4321);  // empty string
      send_beat(1'b1, 8'h61, 16'h0010, 16'h0020);
      send_char(8'h90);                           // restart in the middle of a pair
      send_beat(1'b1, 8'h62, 16'h0030, 16'h0040);
      send_char(CHAR_END);

      // random strings over a range of box setups and flow control mixes
      run_phase(12'd16, 12'd16, 24'h000000, 34, 83, 1'b0);
      run_phase(12'd4095, 12'd4095, 24'hffffff, 34, 83, 1'b0);
      run_phase(12'($urandom_range(16, 160)), 12'($urandom_range(16, 96)), 24'($urandom),
                83, 34, 1'b0);
      run_phase(12'($urandom_range(24, 400)), 12'($urandom_range(16, 200)), 24'($urandom),
                83, 34, 1'b0);
      run_phase(12'($urandom_range(16, 200)), 12'($urandom_range(16, 64)), 24'($urandom),
                0, 0, 1'b1);
      run_phase(12'd4095, 12'd16, 24'($urandom), 0, 0, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_draws != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending_draws == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
